// File: hdl/csvt_pkg.sv
// Shared types and constants for the CSV field tokenizer.
// Used by csvt_core, csvt_emit and csv_field_tokenizer_unit; no dependencies.
package csvt_pkg;

    localparam int TOK_SLOTS = 3;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_EOF  = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;

    localparam logic [2:0] REG_DELIM_CHAR   = 3'd0;
    localparam logic [2:0] REG_DELIM_EN     = 3'd1;
    localparam logic [2:0] REG_QUOTE_CHAR   = 3'd2;
    localparam logic [2:0] REG_ESCAPE_CHAR  = 3'd3;
    localparam logic [2:0] REG_COMMENT_CHAR = 3'd4;
    localparam logic [2:0] REG_COMMENT_EN   = 3'd5;
    localparam logic [2:0] REG_DQUOTE_EN    = 3'd6;
    localparam logic [2:0] REG_OPTIONS      = 3'd7;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic       delimiter_enable;
        logic [7:0] quote_byte;
        logic [7:0] escape_byte;
        logic [7:0] comment_byte;
        logic       comment_enable;
        logic       double_quote_enable;
        logic [2:0] option_flags;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } tok_t;

    typedef struct packed {
        logic [1:0]                 count;
        tok_t [TOK_SLOTS-1:0]       tok;
    } tok_bundle_t;

endpackage

// File: hdl/csvt_core.sv
// Parse state registers and the per-byte token logic of the CSV tokenizer.
// Depends on csvt_pkg for the configuration and token bundle types.
module csvt_core
    import csvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_acc,
    input  logic [7:0]  in_byte,
    input  logic        line_last,
    output tok_bundle_t bundle
);

    localparam logic [1:0] ST_START   = 2'd0;
    localparam logic [1:0] ST_FIELD   = 2'd1;
    localparam logic [1:0] ST_QUOTED  = 2'd2;
    localparam logic [1:0] ST_PENDING = 2'd3;

    logic [1:0] ps_reg;
    logic [1:0] ps_next;
    logic       esc_reg;
    logic       esc_next;
    logic       ad_reg;
    logic       ad_next;
    logic       cs_reg;
    logic       cs_next;

    logic        is_delim;
    logic        is_comment;
    logic        is_quote;
    logic        is_space;
    logic        pushed;
    logic        handled;
    logic [1:0]  st;
    tok_bundle_t b;

    function automatic tok_bundle_t add_tok(input tok_bundle_t cur, input logic [1:0] kind,
                                            input logic [7:0] data);
        tok_bundle_t r;
        r = cur;
        r.tok[cur.count].kind = kind;
        r.tok[cur.count].data = (kind == KIND_DATA) ? data : 8'd0;
        r.count = cur.count + 2'd1;
        return r;
    endfunction

    assign is_delim   = cfg.delimiter_enable && (in_byte == cfg.delimiter_char);
    assign is_comment = cfg.comment_enable && (in_byte == cfg.comment_byte);
    assign is_quote   = (in_byte == cfg.quote_byte);
    assign is_space   = (in_byte == 8'd32) || ((in_byte >= 8'd10) && (in_byte <= 8'd13));

    always_comb
    begin
        b        = '0;
        ps_next  = ps_reg;
        esc_next = esc_reg;
        ad_next  = ad_reg;
        cs_next  = cs_reg;
        pushed   = 1'b0;
        handled  = 1'b0;
        st       = ps_reg;
        if (cfg.option_flags[2])
        begin
            b = add_tok(b, KIND_DATA, in_byte);
            if (line_last)
            begin
                b        = add_tok(b, KIND_EOF, 8'd0);
                b        = add_tok(b, KIND_EOL, 8'd0);
                ps_next  = ST_START;
                esc_next = 1'b0;
                ad_next  = 1'b0;
                cs_next  = 1'b0;
            end
        end
        else
        begin
            if (!cs_reg)
            begin
                if (st == ST_PENDING)
                begin
                    if (is_quote)
                    begin
                        b       = add_tok(b, KIND_DATA, in_byte);
                        pushed  = 1'b1;
                        ps_next = ST_QUOTED;
                        handled = 1'b1;
                    end
                    else
                    begin
                        st = ST_FIELD;
                    end
                end
                if (!handled)
                begin
                    unique case (st)
                        ST_START:
                        begin
                            if (is_quote)
                            begin
                                ad_next = 1'b0;
                                b       = add_tok(b, KIND_DATA, in_byte);
                                pushed  = 1'b1;
                                ps_next = cfg.option_flags[1] ? ST_FIELD : ST_QUOTED;
                            end
                            else if (cfg.option_flags[0] && is_space)
                            begin
                                ad_next = ad_reg;
                            end
                            else if (is_delim)
                            begin
                                ad_next = 1'b1;
                                b       = add_tok(b, KIND_EOF, 8'd0);
                            end
                            else if (is_comment)
                            begin
                                ad_next = 1'b0;
                                cs_next = 1'b1;
                            end
                            else
                            begin
                                ad_next = 1'b0;
                                b       = add_tok(b, KIND_DATA, in_byte);
                                pushed  = 1'b1;
                                ps_next = ST_FIELD;
                            end
                        end
                        ST_FIELD:
                        begin
                            if (is_delim)
                            begin
                                b       = add_tok(b, KIND_EOF, 8'd0);
                                ad_next = 1'b1;
                                ps_next = ST_START;
                            end
                            else if (is_comment)
                            begin
                                b       = add_tok(b, KIND_EOF, 8'd0);
                                ps_next = ST_START;
                                cs_next = 1'b1;
                            end
                            else
                            begin
                                b       = add_tok(b, KIND_DATA, in_byte);
                                pushed  = 1'b1;
                                ps_next = ST_FIELD;
                            end
                        end
                        ST_QUOTED:
                        begin
                            b      = add_tok(b, KIND_DATA, in_byte);
                            pushed = 1'b1;
                            if (is_quote && !esc_reg)
                            begin
                                ps_next = cfg.double_quote_enable ? ST_PENDING : ST_FIELD;
                            end
                        end
                        default:
                        begin
                            ps_next = ps_reg;
                        end
                    endcase
                end
            end
            esc_next = pushed && (in_byte == cfg.escape_byte) && !esc_reg;
            if (line_last)
            begin
                if (!cs_next && ((ps_next != ST_START) || ad_next))
                begin
                    b = add_tok(b, KIND_EOF, 8'd0);
                end
                b        = add_tok(b, KIND_EOL, 8'd0);
                ps_next  = ST_START;
                esc_next = 1'b0;
                ad_next  = 1'b0;
                cs_next  = 1'b0;
            end
        end
    end

    assign bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg  <= ST_START;
            esc_reg <= 1'b0;
            ad_reg  <= 1'b0;
            cs_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            ps_reg  <= ps_next;
            esc_reg <= esc_next;
            ad_reg  <= ad_next;
            cs_reg  <= cs_next;
        end
    end

`ifndef ASSERT_OFF
    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && line_last) |=> (ps_reg == ST_START && !esc_reg && !ad_reg && !cs_reg))
        else $error("Parse state not cleared after the last byte of a line.");
    a_skip_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        cs_reg |-> (ps_reg == ST_START))
        else $error("Comment skip active outside the start-of-field state.");
    a_line_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && line_last) |-> (bundle.count != 2'd0))
        else $error("Last byte of a line produced no token.");
`endif

endmodule

// File: hdl/csvt_emit.sv
// Result register of the CSV tokenizer: holds the tokens of one item and
// hands them out one per cycle while out_stall is low. Depends on csvt_pkg for the token types.
module csvt_emit
    import csvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  tok_bundle_t bundle,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  token_kind,
    output logic [7:0]  token_byte,
    output logic        run_last
);

    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;
    tok_t [TOK_SLOTS-1:0]  tok_reg;
    tok_t [TOK_SLOTS-1:0]  tok_next;
    logic                  take;

    assign out_valid  = (cnt_reg != 2'd0);
    assign take       = out_valid && !out_stall;
    assign can_load   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && take);
    assign token_kind = tok_reg[0].kind;
    assign token_byte = tok_reg[0].data;
    assign run_last   = (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        tok_next = tok_reg;
        if (load)
        begin
            cnt_next = bundle.count;
            tok_next = bundle.tok;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 2'd1;
            tok_next = {tok_reg[TOK_SLOTS-1], tok_reg[TOK_SLOTS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && take)))
        else $error("Tokens loaded over tokens not yet delivered.");
    a_drain_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (take && run_last && !load) |=> (cnt_reg == 2'd0))
        else $error("Buffer not empty after its last token was taken.");
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(token_kind)
            && $stable(token_byte) && $stable(run_last)))
        else $error("Stalled token changed before it was taken.");
`endif

endmodule

// File: hdl/csv_field_tokenizer_unit.sv
// Top level of the CSV field tokenizer: configuration registers, parse core
// and result register. Depends on csvt_pkg, csvt_core and csvt_emit.
//
//   channel | signals                                      | direction
//   input   | in_valid, in_stall, in_byte, line_last       | byte in
//   output  | out_valid, out_stall, token_kind/byte, run_last | token out
//   config  | cfg_we, cfg_index, cfg_data                  | register write
//
// Each byte is parsed in the cycle it is accepted and its zero to three tokens
// are registered; they leave at one token per cycle while out_stall is low, and a
// byte with no token puts nothing on the output.
// A new byte is taken when the buffer is empty or its last token is delivered.
// Reset clears the parse state and the result buffer and loads the register
// defaults; out_stall holds the current token and back-pressures in_stall.
module csv_field_tokenizer_unit
    import csvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       line_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] token_kind,
    output logic [7:0] token_byte,
    output logic       run_last
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    tok_bundle_t bundle;
    logic        can_load;
    logic        in_acc;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELIM_CHAR:   cfg_next.delimiter_char      = cfg_data;
                REG_DELIM_EN:     cfg_next.delimiter_enable    = cfg_data[0];
                REG_QUOTE_CHAR:   cfg_next.quote_byte          = cfg_data;
                REG_ESCAPE_CHAR:  cfg_next.escape_byte         = cfg_data;
                REG_COMMENT_CHAR: cfg_next.comment_byte        = cfg_data;
                REG_COMMENT_EN:   cfg_next.comment_enable      = cfg_data[0];
                REG_DQUOTE_EN:    cfg_next.double_quote_enable = cfg_data[0];
                REG_OPTIONS:      cfg_next.option_flags        = cfg_data[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter_char      <= 8'd44;
            cfg_reg.delimiter_enable    <= 1'b1;
            cfg_reg.quote_byte          <= 8'd34;
            cfg_reg.escape_byte         <= 8'd92;
            cfg_reg.comment_byte        <= 8'd35;
            cfg_reg.comment_enable      <= 1'b0;
            cfg_reg.double_quote_enable <= 1'b1;
            cfg_reg.option_flags        <= 3'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = !can_load;
    assign in_acc   = in_valid && can_load;

    csvt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_acc    (in_acc),
        .in_byte   (in_byte),
        .line_last (line_last),
        .bundle    (bundle)
    );

    csvt_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_acc),
        .bundle     (bundle),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .token_byte (token_byte),
        .run_last   (run_last)
    );

endmodule

// File: tb/csv_field_tokenizer_unit_tb.sv
// Self-checking testbench for csv_field_tokenizer_unit: directed table, then random CSV lines.
// Each token is checked against the table's typed kinds or a behavioral tokenizer in this file.
// Depends on csvt_pkg and the RTL of csv_field_tokenizer_unit.
module csv_field_tokenizer_unit_tb;
    import csvt_pkg::*;

    localparam int LIMIT_CYCLES = 200000;

    typedef enum logic [1:0] {PS_START, PS_FIELD, PS_QUOTED, PS_PENDING} parse_st_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       run_last;
    } token_t;

    typedef struct packed {
        logic       is_cfg;
        logic [2:0] reg_idx;
        logic [7:0] value;
        logic       last;
        logic [1:0] typed_n;
        logic [1:0] tk0;
        logic [1:0] tk1;
        logic [1:0] tk2;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       line_last;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] token_kind;
    logic [7:0] token_byte;
    logic       run_last;

    cfg_t        csv_cfg;
    parse_st_t   parse_st;
    logic        esc_armed;
    logic        after_delim;
    logic        comment_skip;
    token_t      expected_tokens [$];
    logic [7:0]  line_bytes [$];
    dir_row_t    dir_rows [37];
    int          mismatches;
    int          items_sent;
    int          burst_left;
    logic        sender_steady;
    int          cycle_count;
    int          stall_left;
    stall_mode_t stall_mode;

    csv_field_tokenizer_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .line_last  (line_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .token_byte (token_byte),
        .run_last   (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: token %s mismatch, got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_line_state();
        parse_st = PS_START;
        esc_armed = 1'b0;
        after_delim = 1'b0;
        comment_skip = 1'b0;
    endtask

    task automatic expect_token(input token_t t);
        expected_tokens.insert(expected_tokens.size(), t);
    endtask

    task automatic append_byte(input logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endtask

    task automatic tokenize_byte(input logic [7:0] c, input logic last, output int n,
                                 output token_t [3:0] toks);
        logic      is_delim;
        logic      is_comment;
        logic      is_quote;
        logic      pushed;
        logic      handled;
        parse_st_t st;
        n = 0;
        toks = '0;
        pushed = 1'b0;
        handled = 1'b0;
        is_delim = csv_cfg.delimiter_enable && c == csv_cfg.delimiter_char;
        is_comment = csv_cfg.comment_enable && c == csv_cfg.comment_byte;
        is_quote = c == csv_cfg.quote_byte;
        if (csv_cfg.option_flags[2])
        begin
            toks[n] = '{KIND_DATA, c, 1'b0};
            n++;
            if (last)
            begin
                toks[n] = '{KIND_EOF, 8'h00, 1'b0};
                n++;
                toks[n] = '{KIND_EOL, 8'h00, 1'b0};
                n++;
                clear_line_state();
            end
        end
        else
        begin
            if (!comment_skip)
            begin
                st = parse_st;
                if (st == PS_PENDING)
                begin
                    if (is_quote)
                    begin
                        toks[n] = '{KIND_DATA, c, 1'b0};
                        n++;
                        pushed = 1'b1;
                        parse_st = PS_QUOTED;
                        handled = 1'b1;
                    end
                    else
                    begin
                        st = PS_FIELD;
                    end
                end
                if (!handled)
                begin
                    case (st)
                        PS_START:
                        begin
                            if (is_quote)
                            begin
                                after_delim = 1'b0;
                                toks[n] = '{KIND_DATA, c, 1'b0};
                                n++;
                                pushed = 1'b1;
                                parse_st = csv_cfg.option_flags[1] ? PS_FIELD : PS_QUOTED;
                            end
                            else if (csv_cfg.option_flags[0] &&
                                     (c == 8'd32 || (c >= 8'd10 && c <= 8'd13)))
                            begin
                                pushed = 1'b0;
                            end
                            else if (is_delim)
                            begin
                                after_delim = 1'b1;
                                toks[n] = '{KIND_EOF, 8'h00, 1'b0};
                                n++;
                            end
                            else if (is_comment)
                            begin
                                after_delim = 1'b0;
                                comment_skip = 1'b1;
                            end
                            else
                            begin
                                after_delim = 1'b0;
                                toks[n] = '{KIND_DATA, c, 1'b0};
                                n++;
                                pushed = 1'b1;
                                parse_st = PS_FIELD;
                            end
                        end
                        PS_FIELD:
                        begin
                            if (is_delim)
                            begin
                                toks[n] = '{KIND_EOF, 8'h00, 1'b0};
                                n++;
                                after_delim = 1'b1;
                                parse_st = PS_START;
                            end
                            else if (is_comment)
                            begin
                                toks[n] = '{KIND_EOF, 8'h00, 1'b0};
                                n++;
                                parse_st = PS_START;
                                comment_skip = 1'b1;
                            end
                            else
                            begin
                                toks[n] = '{KIND_DATA, c, 1'b0};
                                n++;
                                pushed = 1'b1;
                                parse_st = PS_FIELD;
                            end
                        end
                        PS_QUOTED:
                        begin
                            toks[n] = '{KIND_DATA, c, 1'b0};
                            n++;
                            pushed = 1'b1;
                            if (is_quote && !esc_armed)
                                parse_st = csv_cfg.double_quote_enable ? PS_PENDING : PS_FIELD;
                        end
                        default:
                        begin
                            pushed = pushed;
                        end
                    endcase
                end
            end
            esc_armed = pushed && c == csv_cfg.escape_byte && !esc_armed;
            if (last)
            begin
                if (!comment_skip && (parse_st != PS_START || after_delim))
                begin
                    toks[n] = '{KIND_EOF, 8'h00, 1'b0};
                    n++;
                end
                toks[n] = '{KIND_EOL, 8'h00, 1'b0};
                n++;
                clear_line_state();
            end
        end
        if (n > 0)
            toks[n-1].run_last = 1'b1;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last, input logic [1:0] typed_n,
                             input logic [1:0] tk0, input logic [1:0] tk1,
                             input logic [1:0] tk2);
        int           gap;
        int           n;
        int           i;
        token_t [3:0] toks;
        logic   [5:0] kinds;
        token_t       t;
        gap = 0;
        kinds = {tk2, tk1, tk0};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!sender_steady)
                gap = $urandom_range(0, 7);
        end
        burst_left--;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        line_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        tokenize_byte(b, last, n, toks);
        if (typed_n == 2'd0)
        begin
            for (i = 0; i < n; i++)
                expect_token(toks[i]);
        end
        else
        begin
            for (i = 0; i < typed_n; i++)
            begin
                t.kind = kinds[2*i +: 2];
                t.data = (t.kind == KIND_DATA) ? b : 8'h00;
                t.run_last = (i == typed_n - 1);
                expect_token(t);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DELIM_CHAR:   csv_cfg.delimiter_char = val;
            REG_DELIM_EN:     csv_cfg.delimiter_enable = val[0];
            REG_QUOTE_CHAR:   csv_cfg.quote_byte = val;
            REG_ESCAPE_CHAR:  csv_cfg.escape_byte = val;
            REG_COMMENT_CHAR: csv_cfg.comment_byte = val;
            REG_COMMENT_EN:   csv_cfg.comment_enable = val[0];
            REG_DQUOTE_EN:    csv_cfg.double_quote_enable = val[0];
            default:          csv_cfg.option_flags = val[2:0];
        endcase
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 8))
            0: return 8'h2C;
            1: return 8'h22;
            2: return 8'h5C;
            3: return 8'h23;
            4: return 8'h3B;
            5: return 8'h20;
            6: return 8'h00;
            7: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Mostly well-formed lines of plain and quoted fields; one line in ten is raw noise.
    task automatic build_line();
        int n_fields;
        int k;
        int j;
        int len;
        line_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(1, 10);
            for (j = 0; j < len; j++)
                append_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            n_fields = $urandom_range(1, 4);
            for (k = 0; k < n_fields; k++)
            begin
                if (k > 0)
                    append_byte(csv_cfg.delimiter_char);
                if ($urandom_range(0, 3) == 0)
                    append_byte($urandom_range(0, 1) ? 8'h20 : 8'h0D);
                case ($urandom_range(0, 4))
                    0:
                    begin
                        len = 0;
                    end
                    1, 2:
                    begin
                        len = $urandom_range(1, 4);
                        for (j = 0; j < len; j++)
                            append_byte(plain_byte());
                    end
                    default:
                    begin
                        append_byte(csv_cfg.quote_byte);
                        len = $urandom_range(0, 4);
                        for (j = 0; j < len; j++)
                        begin
                            case ($urandom_range(0, 4))
                                0:
                                begin
                                    append_byte(csv_cfg.escape_byte);
                                    append_byte(csv_cfg.quote_byte);
                                end
                                1:
                                begin
                                    append_byte(csv_cfg.quote_byte);
                                    append_byte(csv_cfg.quote_byte);
                                end
                                2:
                                begin
                                    append_byte(csv_cfg.escape_byte);
                                    append_byte(csv_cfg.escape_byte);
                                end
                                3:
                                begin
                                    append_byte(csv_cfg.delimiter_char);
                                end
                                default:
                                begin
                                    append_byte(plain_byte());
                                end
                            endcase
                        end
                        if ($urandom_range(0, 7) != 0)
                            append_byte(csv_cfg.quote_byte);
                    end
                endcase
            end
            if ($urandom_range(0, 5) == 0)
            begin
                append_byte(csv_cfg.comment_byte);
                append_byte(plain_byte());
            end
            if (line_bytes.size() == 0)
                append_byte(plain_byte());
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (cycle_count % 5) < 2;
        endcase
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin : token_check
        token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                flag_mismatch("unexpected", token_kind, 0);
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (token_kind != want.kind)
                    flag_mismatch("kind", token_kind, want.kind);
                if (token_byte != want.data)
                    flag_mismatch("byte", token_byte, want.data);
                if (run_last != want.run_last)
                    flag_mismatch("run_last", run_last, want.run_last);
            end
        end
    end

    initial
    begin
        int         i;
        int         phase;
        int         r;
        logic [7:0] reg_vals [8];
        dir_row_t   row;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DELIM_CHAR;
        cfg_data <= 8'h00;
        in_valid <= 1'b0;
        in_byte <= 8'h00;
        line_last <= 1'b0;
        out_stall <= 1'b0;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;
        sender_steady = 1'b0;
        cycle_count = 0;
        stall_left = 0;
        stall_mode = STALL_NONE;
        csv_cfg = '{8'd44, 1'b1, 8'd34, 8'd92, 8'd35, 1'b0, 1'b1, 3'd0};
        clear_line_state();
        dir_rows = '{
            '{1'b0, REG_DELIM_CHAR, 8'h61, 1'b0, 2'd1, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h2C, 1'b0, 2'd1, KIND_EOF, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h22, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h78, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h5C, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h22, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h5C, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h5C, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h22, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h22, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h22, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h2C, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'hFF, 1'b0, 2'd1, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h00, 1'b1, 2'd3, KIND_DATA, KIND_EOF, KIND_EOL},
            '{1'b0, REG_DELIM_CHAR, 8'h2C, 1'b1, 2'd3, KIND_EOF, KIND_EOF, KIND_EOL},
            '{1'b1, REG_COMMENT_EN, 8'h01, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b1, REG_OPTIONS, 8'h01, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h20, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h71, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h23, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h7A, 1'b1, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h23, 1'b1, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b1, REG_OPTIONS, 8'h02, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b1, REG_DQUOTE_EN, 8'h00, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h22, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h22, 1'b1, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b1, REG_QUOTE_CHAR, 8'h2C, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b1, REG_ESCAPE_CHAR, 8'hFF, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b1, REG_OPTIONS, 8'h00, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h2C, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h2C, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'hFF, 1'b1, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b1, REG_DELIM_EN, 8'h00, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b1, REG_OPTIONS, 8'h04, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h2C, 1'b0, 2'd1, KIND_DATA, KIND_DATA, KIND_DATA},
            '{1'b0, REG_DELIM_CHAR, 8'h00, 1'b1, 2'd3, KIND_DATA, KIND_EOF, KIND_EOL},
            '{1'b1, REG_COMMENT_CHAR, 8'h00, 1'b0, 2'd0, KIND_DATA, KIND_DATA, KIND_DATA}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(dir_rows); i++)
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                wait_drained();
                write_reg(row.reg_idx, row.value);
            end
            else
            begin
                push_byte(row.value, row.last, row.typed_n, row.tk0, row.tk1, row.tk2);
            end
        end

        for (phase = 0; phase < 7; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    reg_vals[REG_DELIM_CHAR] = 8'd44;
                    reg_vals[REG_DELIM_EN] = 8'd1;
                    reg_vals[REG_QUOTE_CHAR] = 8'd34;
                    reg_vals[REG_ESCAPE_CHAR] = 8'd92;
                    reg_vals[REG_COMMENT_CHAR] = 8'd35;
                    reg_vals[REG_COMMENT_EN] = 8'd1;
                    reg_vals[REG_DQUOTE_EN] = 8'd1;
                    reg_vals[REG_OPTIONS] = 8'd1;
                end
                1:
                begin
                    reg_vals[REG_DELIM_CHAR] = 8'h00;
                    reg_vals[REG_DELIM_EN] = 8'h00;
                    reg_vals[REG_QUOTE_CHAR] = 8'h00;
                    reg_vals[REG_ESCAPE_CHAR] = 8'h00;
                    reg_vals[REG_COMMENT_CHAR] = 8'h00;
                    reg_vals[REG_COMMENT_EN] = 8'h00;
                    reg_vals[REG_DQUOTE_EN] = 8'h00;
                    reg_vals[REG_OPTIONS] = 8'h00;
                end
                2:
                begin
                    reg_vals[REG_DELIM_CHAR] = 8'hFF;
                    reg_vals[REG_DELIM_EN] = 8'h01;
                    reg_vals[REG_QUOTE_CHAR] = 8'hFF;
                    reg_vals[REG_ESCAPE_CHAR] = 8'hFF;
                    reg_vals[REG_COMMENT_CHAR] = 8'hFF;
                    reg_vals[REG_COMMENT_EN] = 8'h01;
                    reg_vals[REG_DQUOTE_EN] = 8'h01;
                    reg_vals[REG_OPTIONS] = 8'h07;
                end
                default:
                begin
                    reg_vals[REG_DELIM_CHAR] = pick_char();
                    reg_vals[REG_DELIM_EN] = ($urandom_range(0, 5) != 0) ? 8'h01 : 8'h00;
                    reg_vals[REG_QUOTE_CHAR] = pick_char();
                    reg_vals[REG_ESCAPE_CHAR] = pick_char();
                    reg_vals[REG_COMMENT_CHAR] = pick_char();
                    reg_vals[REG_COMMENT_EN] = 8'($urandom_range(0, 1));
                    reg_vals[REG_DQUOTE_EN] = 8'($urandom_range(0, 1));
                    reg_vals[REG_OPTIONS] = 8'($urandom_range(0, 3) |
                                               (($urandom_range(0, 3) == 0) ? 4 : 0));
                end
            endcase
            for (r = 0; r < 8; r++)
                write_reg(3'(r), reg_vals[r]);
            sender_steady = (phase % 3 == 1);
            while (items_sent < 26 + 43 * (phase + 1))
            begin
                build_line();
                for (i = 0; i < line_bytes.size(); i++)
                    push_byte(line_bytes[i], i == line_bytes.size() - 1, 2'd0,
                              KIND_DATA, KIND_DATA, KIND_DATA);
            end
        end

        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
